/* hw/rtl/rgbycc_pkg.sv */
// Shared constants, register indexes and helpers for the RGB to YCbCr 4:2:0 converter.
package rgbycc_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int SUM_W     = 25;

    localparam int MAX_DIMENSION_DEFAULT = 4096;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd1080;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // Q16 coefficients
    localparam logic [COEF_W-1:0] COEF_Y_R  = 16'd19595;
    localparam logic [COEF_W-1:0] COEF_Y_G  = 16'd38470;
    localparam logic [COEF_W-1:0] COEF_Y_B  = 16'd7471;
    localparam logic [COEF_W-1:0] COEF_CB_R = 16'd11056;
    localparam logic [COEF_W-1:0] COEF_CB_G = 16'd21712;
    localparam logic [COEF_W-1:0] COEF_CR_G = 16'd27440;
    localparam logic [COEF_W-1:0] COEF_CR_B = 16'd5328;
    localparam logic [COEF_W-1:0] COEF_HALF = 16'd32768;
    localparam logic [SUM_W-1:0]  OFFSET_Q16 = 25'd8388608;

    function automatic logic [PIX_W-1:0] sat8(input logic [PIX_W:0] v);
        sat8 = v[PIX_W] ? {PIX_W{1'b1}} : v[PIX_W-1:0];
    endfunction

endpackage

/* hw/rtl/rgbycc_ifs.sv */
// Valid/ready channel interfaces for pixels, results and configuration writes.
interface rgbycc_pix_if
    import rgbycc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbycc_ycc_if
    import rgbycc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             end_of_frame;

    modport source (output valid, output luma, output chroma_valid, output chroma_blue,
                    output chroma_red, output end_of_frame, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input chroma_blue,
                    input chroma_red, input end_of_frame, output ready);
endinterface

interface rgbycc_cfg_if
    import rgbycc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rgbycc_csc.sv */
// Fixed-point color space conversion of one pixel to Y, Cb and Cr.
module rgbycc_csc
    import rgbycc_pkg::*;
(
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic             site,
    output logic [PIX_W-1:0] luma,
    output logic [PIX_W-1:0] chroma_blue,
    output logic [PIX_W-1:0] chroma_red
);

    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;

    // All sums stay non-negative for 8-bit inputs, so unsigned math is exact.
    assign y_sum  = SUM_W'(COEF_Y_R) * SUM_W'(red)
                  + SUM_W'(COEF_Y_G) * SUM_W'(green)
                  + SUM_W'(COEF_Y_B) * SUM_W'(blue);
    assign cb_sum = OFFSET_Q16 + SUM_W'(COEF_HALF) * SUM_W'(blue)
                  - SUM_W'(COEF_CB_R) * SUM_W'(red)
                  - SUM_W'(COEF_CB_G) * SUM_W'(green);
    assign cr_sum = OFFSET_Q16 + SUM_W'(COEF_HALF) * SUM_W'(red)
                  - SUM_W'(COEF_CR_G) * SUM_W'(green)
                  - SUM_W'(COEF_CR_B) * SUM_W'(blue);

    assign luma        = sat8(y_sum[SUM_W-1:16]);
    assign chroma_blue = site ? sat8(cb_sum[SUM_W-1:16]) : '0;
    assign chroma_red  = site ? sat8(cr_sum[SUM_W-1:16]) : '0;

endmodule

/* hw/rtl/rgb_to_ycbcr_420_converter.sv */
// Top level of the RGB to full-range YCbCr 4:2:0 converter.
// Path: an accepted pixel beat passes the input register, then the result register after
//   the color conversion, before it leaves as a result beat.
// Throughput: one pixel per cycle; both stages advance together, so a waiting result
//   only stalls the input once both registers are full.
// Reset: rst_n asynchronously clears both stage valids and the position counters, and
//   loads frame_width 1920 and frame_height 1080.
module rgb_to_ycbcr_420_converter
    import rgbycc_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    rgbycc_pix_if.sink         pixel,
    rgbycc_ycc_if.source       result,
    rgbycc_cfg_if.sink         cfg
);

    // Counter holds 0..MAX_DIMENSION-1; clamped dimensions hold up to MAX_DIMENSION.
    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    localparam logic [CMP_W-1:0] DIM_MIN = CMP_W'(2);
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIMENSION);
    localparam logic [CMP_W-1:0] ONE     = CMP_W'(1);

    // Configuration registers
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // Raster position of the next pixel
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg,    row_count_next;

    // Stage control
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s2_free;
    logic s1_move;
    logic pix_acc;

    // Stage 1 payload: pixel plus the position flags decided at acceptance
    logic [PIX_W-1:0] s1_red_reg;
    logic [PIX_W-1:0] s1_green_reg;
    logic [PIX_W-1:0] s1_blue_reg;
    logic             s1_site_reg;
    logic             s1_eof_reg;

    // Stage 2 payload: the result beat
    logic [PIX_W-1:0] s2_luma_reg;
    logic             s2_site_reg;
    logic [PIX_W-1:0] s2_cb_reg;
    logic [PIX_W-1:0] s2_cr_reg;
    logic             s2_eof_reg;

    // Position decode
    logic [CMP_W-1:0] width_ext, height_ext;
    logic [CMP_W-1:0] width_clamp, height_clamp;
    logic [CMP_W-1:0] col_ext, row_ext;
    logic             row_end, frame_end, site;

    logic [PIX_W-1:0] csc_luma, csc_cb, csc_cr;

    //------------------------------------------------------------------
    // Configuration writes: always ready, unknown indexes are dropped.
    //------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Clamp the dimensions to 2..MAX_DIMENSION and decode the position.
    //------------------------------------------------------------------
    assign width_ext  = CMP_W'(frame_width_reg);
    assign height_ext = CMP_W'(frame_height_reg);

    always_comb
    begin
        if (width_ext < DIM_MIN)
            width_clamp = DIM_MIN;
        else if (width_ext > DIM_MAX)
            width_clamp = DIM_MAX;
        else
            width_clamp = width_ext;

        if (height_ext < DIM_MIN)
            height_clamp = DIM_MIN;
        else if (height_ext > DIM_MAX)
            height_clamp = DIM_MAX;
        else
            height_clamp = height_ext;
    end

    assign col_ext = CMP_W'(column_count_reg);
    assign row_ext = CMP_W'(row_count_reg);

    // A counter left past the end by a shrunk dimension counts as at the end.
    assign row_end   = col_ext >= (width_clamp - ONE);
    assign frame_end = row_end && (row_ext >= (height_clamp - ONE));

    // Chroma sites: even column and row, inside the even-sized area.
    assign site = !column_count_reg[0] && !row_count_reg[0]
               && (col_ext < (width_clamp & ~ONE))
               && (row_ext < (height_clamp & ~ONE));

    //------------------------------------------------------------------
    // Handshake: advance stage 1 into stage 2 whenever stage 2 drains.
    //------------------------------------------------------------------
    assign s2_free     = !s2_valid_reg || result.ready;
    assign s1_move     = s1_valid_reg && s2_free;
    assign pixel.ready = !s1_valid_reg || s2_free;
    assign pix_acc     = pixel.valid && pixel.ready;

    always_comb
    begin
        if (pix_acc)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            s2_valid_next = 1'b1;
        else if (result.ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    // Step the raster counters on every accepted pixel; wrap at row and frame end.
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (pix_acc)
        begin
            if (row_end)
            begin
                column_count_next = '0;
                row_count_next    = frame_end ? '0 : row_count_reg + CNT_W'(1);
            end
            else
            begin
                column_count_next = column_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    //------------------------------------------------------------------
    // Payload registers: capture on accept, hold while stalled.
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_red_reg   <= pixel.red;
            s1_green_reg <= pixel.green;
            s1_blue_reg  <= pixel.blue;
            s1_site_reg  <= site;
            s1_eof_reg   <= frame_end;
        end
    end

    rgbycc_csc u_csc (
        .red         (s1_red_reg),
        .green       (s1_green_reg),
        .blue        (s1_blue_reg),
        .site        (s1_site_reg),
        .luma        (csc_luma),
        .chroma_blue (csc_cb),
        .chroma_red  (csc_cr)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_luma_reg <= csc_luma;
            s2_site_reg <= s1_site_reg;
            s2_cb_reg   <= csc_cb;
            s2_cr_reg   <= csc_cr;
            s2_eof_reg  <= s1_eof_reg;
        end
    end

    // Result beat
    assign result.valid        = s2_valid_reg;
    assign result.luma         = s2_luma_reg;
    assign result.chroma_valid = s2_site_reg;
    assign result.chroma_blue  = s2_cb_reg;
    assign result.chroma_red   = s2_cr_reg;
    assign result.end_of_frame = s2_eof_reg;

endmodule

/* hw/rtl/rgbycc_checker.sv */
// Port-level assertions for the converter, with the bind that attaches them.
module rgbycc_checker
    import rgbycc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [PIX_W-1:0] res_luma,
    input logic             res_chroma_valid,
    input logic [PIX_W-1:0] res_chroma_blue,
    input logic [PIX_W-1:0] res_chroma_red,
    input logic             res_end_of_frame
);

    // Hold a stalled result beat unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_luma)
            && $stable(res_chroma_valid) && $stable(res_chroma_blue)
            && $stable(res_chroma_red) && $stable(res_end_of_frame))
        else $error("stalled result beat changed");

    // A rising result valid stems from a pixel accepted into the input register and moved on unstalled.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result beat without a pixel two cycles earlier");

    // Non-site pixels carry zero chroma.
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_chroma_valid |-> res_chroma_blue == '0 && res_chroma_red == '0)
        else $error("chroma nonzero outside a sample site");

    // The last pixel of a frame is never a chroma site.
    a_eof_no_site: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_end_of_frame |-> !res_chroma_valid)
        else $error("end of frame on a chroma site");

endmodule

bind rgb_to_ycbcr_420_converter rgbycc_checker u_rgbycc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (pixel.valid),
    .pix_ready        (pixel.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_luma         (result.luma),
    .res_chroma_valid (result.chroma_valid),
    .res_chroma_blue  (result.chroma_blue),
    .res_chroma_red   (result.chroma_red),
    .res_end_of_frame (result.end_of_frame)
);

/* sim/ycc_stream_checker.sv */
// Checker: predicts each YCbCr 4:2:0 result beat from the pixel stream and compares it.
module ycc_stream_checker
    import rgbycc_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    rgbycc_pix_if pixel,
    rgbycc_ycc_if result,
    rgbycc_cfg_if cfg,
    output int    pending,
    output int    mismatches,
    output int    frames_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             end_of_frame;
    } ycc_beat_t;

    ycc_beat_t        ycc_due[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_DIMENSION)
            return MAX_DIMENSION;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] clip_byte(input int unsigned v);
        return (v > 255) ? 8'hFF : v[PIX_W-1:0];
    endfunction

    // Convert one pixel at the current position, then advance the raster position.
    function automatic ycc_beat_t convert_pixel(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned rr;
        int unsigned gg;
        int unsigned bb;
        logic        row_end;
        logic        frame_end;
        logic        site;
        ycc_beat_t   beat;
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        rr = r;
        gg = g;
        bb = b;
        row_end   = (col_pos >= w - 1);
        frame_end = row_end && (row_pos >= h - 1);
        site = (col_pos[0] == 1'b0) && (row_pos[0] == 1'b0) &&
               (col_pos < (w & ~32'd1)) && (row_pos < (h & ~32'd1));
        beat.luma = clip_byte((19595 * rr + 38470 * gg + 7471 * bb) >> 16);
        beat.chroma_valid = site;
        beat.chroma_blue  = '0;
        beat.chroma_red   = '0;
        if (site)
        begin
            beat.chroma_blue = clip_byte((8388608 + 32768 * bb - 11056 * rr - 21712 * gg) >> 16);
            beat.chroma_red  = clip_byte((8388608 + 32768 * rr - 27440 * gg - 5328 * bb) >> 16);
        end
        beat.end_of_frame = frame_end;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return beat;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got, inout int errs);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ycc_beat_t want;
        int        errs;
        if (!rst_n)
        begin
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            col_pos    = 0;
            row_pos    = 0;
            ycc_due.delete();
            pending     <= 0;
            mismatches  <= 0;
            frames_done <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FRAME_WIDTH)
                    width_reg = cfg.data;
                else if (cfg.index == REG_FRAME_HEIGHT)
                    height_reg = cfg.data;
            end
            if (result.valid && result.ready)
            begin
                if (ycc_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual luma %0d",
                             $time, result.luma);
                    errs++;
                end
                else
                begin
                    want = ycc_due.pop_front();
                    check_field("luma", want.luma, result.luma, errs);
                    check_field("chroma_valid", want.chroma_valid, result.chroma_valid, errs);
                    check_field("chroma_blue", want.chroma_blue, result.chroma_blue, errs);
                    check_field("chroma_red", want.chroma_red, result.chroma_red, errs);
                    check_field("end_of_frame", want.end_of_frame, result.end_of_frame, errs);
                    if (want.end_of_frame)
                        frames_done <= frames_done + 1;
                end
            end
            if (pixel.valid && pixel.ready)
                ycc_due.push_back(convert_pixel(pixel.red, pixel.green, pixel.blue));
            pending    <= ycc_due.size();
            mismatches <= mismatches + errs;
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the converter testbench: clock, reset, pixel and register stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbycc_pkg::*;

    localparam int GAP_MAX       = 8;
    localparam int RANDOM_PIXELS = 760;
    localparam int DRAIN_CYCLES  = 4;

    logic clk = 1'b0;
    logic rst_n;

    // Set per phase: when high, that side runs without idle cycles.
    bit src_calm;
    bit snk_calm;

    int unsigned pixels_sent;
    int unsigned settings_run;
    int          pending;
    int          mismatches;
    int          frames_done;

    rgbycc_pix_if pix_ch();
    rgbycc_ycc_if ycc_ch();
    rgbycc_cfg_if cfg_ch();

    rgb_to_ycbcr_420_converter #(
        .MAX_DIMENSION(MAX_DIMENSION_DEFAULT)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .result (ycc_ch),
        .cfg    (cfg_ch)
    );

    ycc_stream_checker #(
        .MAX_DIMENSION(MAX_DIMENSION_DEFAULT)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pix_ch),
        .result      (ycc_ch),
        .cfg         (cfg_ch),
        .pending     (pending),
        .mismatches  (mismatches),
        .frames_done (frames_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Bias channel values toward the ends of the range.
    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly tiny frames so rows and frames close often; now and then an
    // out-of-range or maximal size.
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return CFG_W'($urandom_range(0, 1));
            1:       return CFG_W'($urandom_range(4096, 8191));
            2:       return ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd8191;
            default: return CFG_W'($urandom_range(2, 9));
        endcase
    endfunction

    // Send one pixel beat. Valid stays high on return so a back-to-back beat
    // never drops it within the same step.
    task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Write one register, then drop valid before returning.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the pixel stream until every expected result beat is back,
    // then let the pipeline idle before returning.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned random_base;
        rst_n        <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data  <= '0;
        src_calm     = 1'b0;
        snk_calm     = 1'b0;
        pixels_sent  = 0;
        settings_run = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size 1920x1080: the first pixel is the chroma site at the
        // origin, the next ones alternate. Walk the channel extremes.
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 8'h00, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'hFF);
        settings_run++;

        // Shrink to 3x3 while the column counter sits past the new row end:
        // the next beat closes the row. Then cover the odd trailing column and
        // row, the end of frame and the wrap back to the origin.
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        settings_run++;
        push_pixel(8'h80, 8'h80, 8'h80);
        push_pixel(8'hFF, 8'h00, 8'hFF);
        push_pixel(8'h00, 8'hFF, 8'h00);
        push_pixel(8'h01, 8'hFE, 8'h7F);
        push_pixel(8'hFF, 8'h00, 8'h00);
        push_pixel(8'h00, 8'h00, 8'hFF);
        push_pixel(8'h55, 8'hAA, 8'h55);
        push_pixel(8'h00, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h00, 8'h00, 8'h00);

        // Sizes below the minimum act as 2x2; a write to an unknown index
        // changes nothing.
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        write_reg(REG_FRAME_HEIGHT + CFG_IDX_W'(1), 13'd5);
        settings_run++;
        push_pixel(8'hFF, 8'h00, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'h7F, 8'h80, 8'h81);

        // Random phases: new size, random idling mode, burst of pixels. Each
        // phase starts from a drained pipeline, and the counters carry over,
        // so shrinking mid-frame happens often.
        random_base = pixels_sent;
        while (pixels_sent - random_base < RANDOM_PIXELS)
        begin
            settle();
            write_reg(REG_FRAME_WIDTH, pick_dim());
            write_reg(REG_FRAME_HEIGHT, pick_dim());
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
            settings_run++;
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(8, 48))
                push_pixel(pick_byte(), pick_byte(), pick_byte());
        end

        settle();
        $display("Run: %0d pixel beats over %0d frame-size settings, %0d frames closed.",
                 pixels_sent, settings_run, frames_done);
        $display("Sizes spanned clamped low and high, odd, and shrunk mid-frame.");
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result sink: after each accepted beat draw a random stall (none when snk_calm is
    // set) and hold ready low while it counts down.
    initial
    begin
        int unsigned stall;
        stall = 0;
        ycc_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (ycc_ch.valid && ycc_ch.ready)
            begin
                stall = snk_calm ? 0 : $urandom_range(0, GAP_MAX);
                ycc_ch.ready <= (stall == 0);
            end
            else if (stall != 0)
            begin
                stall--;
                ycc_ch.ready <= (stall == 0);
            end
            else
                ycc_ch.ready <= 1'b1;
        end
    end

endmodule
